FILE: rtl/paged_fixed_block_pool_allocator_assert.svh
// assertion macros for the block pool allocator
`ifndef PAGED_FIXED_BLOCK_POOL_ALLOCATOR_ASSERT_SVH
`define PAGED_FIXED_BLOCK_POOL_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define PFA_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pfa check failed");
`define PFA_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pfa check failed");
`else
`define PFA_ASSERT_IMP(name, ante, cons)
`define PFA_ASSERT_NXT(name, ante, cons)
`endif
`endif

FILE: rtl/pfa_pkg.sv
// shared constants, codes and types of the block pool allocator
package pfa_pkg;

    localparam int MAX_PAGES           = 16;
    localparam int MAX_BLOCKS_PER_PAGE = 16;
    localparam int POINTER_BYTES       = 8;
    localparam int PAGE_OFFSET_BITS    = 16;
    localparam int ADDR_W              = 20;
    localparam int PAGE_W              = $clog2(MAX_PAGES);
    localparam int SLOT_W              = $clog2(MAX_BLOCKS_PER_PAGE);
    localparam int POOL_CAPACITY       = MAX_PAGES * MAX_BLOCKS_PER_PAGE;
    localparam int IDX_W               = PAGE_W + SLOT_W;
    localparam int CNT_W               = IDX_W + 1;
    localparam int PAGES_W             = 5;
    localparam int PADDR_W             = 5;

    typedef enum logic [1:0] {
        KIND_INIT  = 2'd0,
        KIND_ALLOC = 2'd1,
        KIND_FREE  = 2'd2
    } pfa_kind_t;

    typedef enum logic [1:0] {
        STATUS_OK            = 2'd0,
        STATUS_NO_PAGES      = 2'd1,
        STATUS_BAD_BOUNDARY  = 2'd2,
        STATUS_MULTIPLE_FREE = 2'd3
    } pfa_status_t;

    typedef enum logic [2:0] {
        REG_OBJECT_BYTES    = 3'd0,
        REG_PAD_BYTES       = 3'd1,
        REG_HEADER_BYTES    = 3'd2,
        REG_ALIGNMENT_BYTES = 3'd3,
        REG_BLOCKS_PER_PAGE = 3'd4,
        REG_PAGE_LIMIT      = 3'd5,
        REG_DEBUG_CHECKS    = 3'd6
    } pfa_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LAYOUT_A,
        ST_LAYOUT_B,
        ST_LAYOUT_C,
        ST_DISPATCH,
        ST_PUSH,
        ST_POP,
        ST_GRANT,
        ST_DECODE,
        ST_RELEASE,
        ST_DONE
    } pfa_state_t;

    typedef struct packed {
        logic [12:0] object_bytes;
        logic [6:0]  pad_bytes;
        logic [5:0]  header_bytes;
        logic [8:0]  alignment_bytes;
        logic [4:0]  blocks_per_page;
        logic [4:0]  page_limit;
        logic        debug_checks;
    } pfa_cfg_t;

    localparam pfa_cfg_t CFG_RESET = '{
        object_bytes:    13'd8,
        pad_bytes:       7'd0,
        header_bytes:    6'd0,
        alignment_bytes: 9'd0,
        blocks_per_page: 5'd4,
        page_limit:      5'd16,
        debug_checks:    1'b0
    };

    typedef struct packed {
        logic capture;
        logic layout_a;
        logic layout_b;
        logic layout_c;
        logic init_clear;
        logic push;
        logic no_pages;
        logic pop;
        logic grant;
        logic decode_start;
        logic decode_step;
        logic release_blk;
        logic load_result;
    } pfa_cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       stack_empty;
        logic       can_grow;
        logic       push_last;
        logic       precheck_ok;
        logic       dec_hit;
        logic       dec_miss;
    } pfa_stat_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [ADDR_W-1:0] granted_address;
        logic [CNT_W-1:0]  objects_in_use;
        logic [CNT_W-1:0]  free_blocks;
        logic [PAGES_W-1:0] pages_in_use;
        logic [CNT_W-1:0]  peak_objects;
        logic [31:0]       allocation_count;
        logic [31:0]       release_count;
    } pfa_result_t;

endpackage

FILE: rtl/pfa_if.sv
// request and result channel interfaces
interface pfa_req_if;
    import pfa_pkg::*;
    logic              valid;
    logic              ready;
    logic [1:0]        kind;
    logic [ADDR_W-1:0] block_address;
    modport source (output valid, kind, block_address, input ready);
    modport sink (input valid, kind, block_address, output ready);
endinterface

interface pfa_res_if;
    import pfa_pkg::*;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [ADDR_W-1:0]  granted_address;
    logic [CNT_W-1:0]   objects_in_use;
    logic [CNT_W-1:0]   free_blocks;
    logic [PAGES_W-1:0] pages_in_use;
    logic [CNT_W-1:0]   peak_objects;
    logic [31:0]        allocation_count;
    logic [31:0]        release_count;
    modport source (output valid, status, granted_address, objects_in_use, free_blocks,
                    pages_in_use, peak_objects, allocation_count, release_count,
                    input ready);
    modport sink (input valid, status, granted_address, objects_in_use, free_blocks,
                  pages_in_use, peak_objects, allocation_count, release_count,
                  output ready);
endinterface

FILE: rtl/pfa_regs.sv
// configuration register file on the apb port
module pfa_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pfa_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output pfa_pkg::pfa_cfg_t           cfg
);
    import pfa_pkg::*;

    pfa_cfg_t cfg_reg;
    pfa_cfg_t cfg_next;
    pfa_reg_t reg_idx;
    logic     wr_en;

    assign reg_idx = pfa_reg_t'(paddr[PADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_OBJECT_BYTES:    cfg_next.object_bytes    = pwdata[12:0];
                REG_PAD_BYTES:       cfg_next.pad_bytes       = pwdata[6:0];
                REG_HEADER_BYTES:    cfg_next.header_bytes    = pwdata[5:0];
                REG_ALIGNMENT_BYTES: cfg_next.alignment_bytes = pwdata[8:0];
                REG_BLOCKS_PER_PAGE: cfg_next.blocks_per_page = pwdata[4:0];
                REG_PAGE_LIMIT:      cfg_next.page_limit      = pwdata[4:0];
                REG_DEBUG_CHECKS:    cfg_next.debug_checks    = pwdata[0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_OBJECT_BYTES:    prdata = {19'd0, cfg_reg.object_bytes};
            REG_PAD_BYTES:       prdata = {25'd0, cfg_reg.pad_bytes};
            REG_HEADER_BYTES:    prdata = {26'd0, cfg_reg.header_bytes};
            REG_ALIGNMENT_BYTES: prdata = {23'd0, cfg_reg.alignment_bytes};
            REG_BLOCKS_PER_PAGE: prdata = {27'd0, cfg_reg.blocks_per_page};
            REG_PAGE_LIMIT:      prdata = {27'd0, cfg_reg.page_limit};
            REG_DEBUG_CHECKS:    prdata = {31'd0, cfg_reg.debug_checks};
            default:             prdata = 32'd0;
        endcase
    end
endmodule

FILE: rtl/pfa_ctrl.sv
// sequencing state machine of the block pool allocator
module pfa_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  pfa_pkg::pfa_stat_t stat,
    output pfa_pkg::pfa_cmd_t  cmd
);
    import pfa_pkg::*;

    pfa_state_t state_reg;
    pfa_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_LAYOUT_A;
                end
            end
            ST_LAYOUT_A: state_next = ST_LAYOUT_B;
            ST_LAYOUT_B: state_next = ST_LAYOUT_C;
            ST_LAYOUT_C: state_next = ST_DISPATCH;
            ST_DISPATCH:
            begin
                priority if (stat.kind == KIND_INIT)
                begin
                    state_next = ST_PUSH;
                end
                else if (stat.kind == KIND_ALLOC)
                begin
                    priority if (!stat.stack_empty)
                        state_next = ST_POP;
                    else if (stat.can_grow)
                        state_next = ST_PUSH;
                    else
                        state_next = ST_DONE;
                end
                else if (stat.kind == KIND_FREE)
                begin
                    state_next = stat.precheck_ok ? ST_DECODE : ST_RELEASE;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_PUSH:
            begin
                if (stat.push_last)
                begin
                    state_next = (stat.kind == KIND_INIT) ? ST_DONE : ST_POP;
                end
            end
            ST_POP:   state_next = ST_GRANT;
            ST_GRANT: state_next = ST_DONE;
            ST_DECODE:
            begin
                if (stat.dec_hit || stat.dec_miss)
                begin
                    state_next = ST_RELEASE;
                end
            end
            ST_RELEASE: state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd              = '0;
        cmd.capture      = (state_reg == ST_IDLE) && in_valid;
        cmd.layout_a     = (state_reg == ST_LAYOUT_A);
        cmd.layout_b     = (state_reg == ST_LAYOUT_B);
        cmd.layout_c     = (state_reg == ST_LAYOUT_C);
        cmd.init_clear   = (state_reg == ST_DISPATCH) && (stat.kind == KIND_INIT);
        cmd.no_pages     = (state_reg == ST_DISPATCH) && (stat.kind == KIND_ALLOC)
                           && stat.stack_empty && !stat.can_grow;
        cmd.decode_start = (state_reg == ST_DISPATCH) && (stat.kind == KIND_FREE);
        cmd.push         = (state_reg == ST_PUSH);
        cmd.pop          = (state_reg == ST_POP);
        cmd.grant        = (state_reg == ST_GRANT);
        cmd.decode_step  = (state_reg == ST_DECODE);
        cmd.release_blk  = (state_reg == ST_RELEASE);
        cmd.load_result  = (state_reg == ST_DONE) && out_free;
    end

    always_comb
    begin
        priority if (cmd.load_result)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end
endmodule

FILE: rtl/pfa_dp.sv
// layout, free stack, decode and counters of the block pool allocator
module pfa_dp (
    input  logic                       clk,
    input  logic                       rst_n,
    input  pfa_pkg::pfa_cfg_t          cfg,
    input  logic [1:0]                 in_kind,
    input  logic [pfa_pkg::ADDR_W-1:0] in_addr,
    input  pfa_pkg::pfa_cmd_t          cmd,
    output pfa_pkg::pfa_stat_t         stat,
    output pfa_pkg::pfa_result_t       res
);
    import pfa_pkg::*;

    // captured item and layout
    logic [1:0]        kind_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [12:0]       obj_reg;
    logic [13:0]       body_reg;
    logic [9:0]        left_reg;
    logic [9:0]        inter_reg;
    logic [4:0]        nblk_reg;
    logic [4:0]        limit_reg;
    logic [14:0]       stride_reg;
    logic [10:0]       first_reg;
    logic [19:0]       page_size_reg;

    // pool state
    logic [CNT_W-1:0]         depth_reg, depth_next;
    logic [PAGES_W-1:0]       pages_reg, pages_next;
    logic [CNT_W-1:0]         in_use_reg, in_use_next;
    logic [CNT_W-1:0]         peak_reg, peak_next;
    logic [31:0]              alloc_total_reg, alloc_total_next;
    logic [31:0]              release_total_reg, release_total_next;
    logic [POOL_CAPACITY-1:0] alloc_bits_reg, alloc_bits_next;
    logic [SLOT_W-1:0]        k_reg, k_next;
    logic                     dec_ok_reg, dec_ok_next;
    logic [1:0]               status_reg;
    logic [ADDR_W-1:0]        granted_reg;
    logic [15:0]              rem_reg;
    logic [4:0]               slot_reg;
    logic [IDX_W-1:0]         rd_reg;
    pfa_result_t              res_reg;

    logic [IDX_W-1:0] stack_mem [POOL_CAPACITY];

    // layout terms
    logic [9:0]  a10, two_a, n1, n2, left_c, inter_c;
    logic [12:0] obj_c;
    logic [4:0]  nblk_c, limit_c;
    // item terms
    logic [15:0]             off;
    logic [PAGE_W-1:0]       page;
    logic [IDX_W-1:0]        push_idx, rel_idx, depth_m1;
    logic [SLOT_W-1:0]       g_slot;
    logic [PAGE_W-1:0]       g_page;
    logic [19:0]             g_off;
    logic                    rel_accept;
    logic [1:0]              rel_status;
    logic                    mem_we;
    logic [IDX_W-1:0]        mem_wdata;
    logic                    stack_full;

    assign a10     = {1'b0, cfg.alignment_bytes};
    assign two_a   = {cfg.alignment_bytes, 1'b0};
    assign n1      = 10'(POINTER_BYTES) + 10'(cfg.pad_bytes) + 10'(cfg.header_bytes);
    assign n2      = 10'(cfg.header_bytes) + {2'd0, cfg.pad_bytes, 1'b0};
    // gaps fold to zero where they would go negative
    assign left_c  = (cfg.alignment_bytes == '0) ? 10'd0 :
                     (n1 <= a10) ? a10 - n1 : (two_a > n1) ? two_a - n1 : 10'd0;
    assign inter_c = (cfg.alignment_bytes == '0) ? 10'd0 :
                     (n2 < a10) ? a10 - n2 : (two_a > n2) ? two_a - n2 : 10'd0;
    assign obj_c   = (cfg.object_bytes < 13'(POINTER_BYTES)) ? 13'(POINTER_BYTES)
                                                             : cfg.object_bytes;
    assign nblk_c  = (cfg.blocks_per_page == '0) ? 5'd1 :
                     (cfg.blocks_per_page > 5'(MAX_BLOCKS_PER_PAGE)) ?
                     5'(MAX_BLOCKS_PER_PAGE) : cfg.blocks_per_page;
    assign limit_c = (cfg.page_limit > 5'(MAX_PAGES)) ? 5'(MAX_PAGES) : cfg.page_limit;

    assign off        = addr_reg[PAGE_OFFSET_BITS-1:0];
    assign page       = addr_reg[ADDR_W-1:PAGE_OFFSET_BITS];
    assign stack_full = depth_reg[CNT_W-1];
    assign push_idx   = {pages_reg[PAGE_W-1:0], k_reg};
    assign rel_idx    = {page, slot_reg[SLOT_W-1:0]};
    assign depth_m1   = IDX_W'(depth_reg - CNT_W'(1));
    assign g_slot     = rd_reg[SLOT_W-1:0];
    assign g_page     = rd_reg[IDX_W-1:SLOT_W];
    assign g_off      = 20'(first_reg) + 20'(g_slot) * 20'(stride_reg);

    // free outcome
    always_comb
    begin
        rel_accept = dec_ok_reg;
        rel_status = STATUS_OK;
        if (cfg.debug_checks)
        begin
            priority if (!dec_ok_reg)
            begin
                rel_accept = 1'b0;
                rel_status = STATUS_BAD_BOUNDARY;
            end
            else if (!alloc_bits_reg[rel_idx])
            begin
                rel_accept = 1'b0;
                rel_status = STATUS_MULTIPLE_FREE;
            end
            else
            begin
                rel_accept = 1'b1;
            end
        end
    end

    assign mem_we    = !stack_full && (cmd.push || (cmd.release_blk && rel_accept));
    assign mem_wdata = cmd.push ? push_idx : rel_idx;

    assign stat.kind        = kind_reg;
    assign stat.stack_empty = (depth_reg == '0);
    assign stat.can_grow    = (pages_reg < limit_reg);
    assign stat.push_last   = ({1'b0, k_reg} == (nblk_reg - 5'd1));
    assign stat.precheck_ok = ({1'b0, page} < pages_reg) && (off != '0)
                              && (20'(off) < page_size_reg) && (off >= 16'(first_reg));
    assign stat.dec_hit     = (rem_reg == '0);
    assign stat.dec_miss    = (rem_reg != '0) && ((rem_reg < 16'(stride_reg))
                              || ((slot_reg + 5'd1) >= nblk_reg));

    always_comb
    begin
        depth_next         = depth_reg;
        pages_next         = pages_reg;
        in_use_next        = in_use_reg;
        peak_next          = peak_reg;
        alloc_total_next   = alloc_total_reg;
        release_total_next = release_total_reg;
        alloc_bits_next    = alloc_bits_reg;
        k_next             = k_reg;
        dec_ok_next        = dec_ok_reg;
        if (cmd.capture)
        begin
            k_next = '0;
        end
        if (cmd.init_clear)
        begin
            depth_next         = '0;
            pages_next         = '0;
            in_use_next        = '0;
            peak_next          = '0;
            alloc_total_next   = '0;
            release_total_next = '0;
            alloc_bits_next    = '0;
        end
        if (cmd.decode_start)
        begin
            dec_ok_next = 1'b0;
        end
        if (cmd.decode_step && stat.dec_hit)
        begin
            dec_ok_next = 1'b1;
        end
        if (cmd.push)
        begin
            if (!stack_full)
            begin
                depth_next = depth_reg + CNT_W'(1);
            end
            k_next = k_reg + SLOT_W'(1);
            if (stat.push_last)
            begin
                pages_next = pages_reg + PAGES_W'(1);
            end
        end
        if (cmd.pop)
        begin
            depth_next = depth_reg - CNT_W'(1);
        end
        if (cmd.grant)
        begin
            alloc_bits_next[rd_reg] = 1'b1;
            in_use_next             = in_use_reg + CNT_W'(1);
            if (in_use_next > peak_reg)
            begin
                peak_next = in_use_next;
            end
            alloc_total_next = alloc_total_reg + 32'd1;
        end
        if (cmd.release_blk && rel_accept)
        begin
            alloc_bits_next[rel_idx] = 1'b0;
            if (!stack_full)
            begin
                depth_next = depth_reg + CNT_W'(1);
            end
            if (in_use_reg != '0)
            begin
                in_use_next = in_use_reg - CNT_W'(1);
            end
            release_total_next = release_total_reg + 32'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg         <= '0;
            pages_reg         <= '0;
            in_use_reg        <= '0;
            peak_reg          <= '0;
            alloc_total_reg   <= '0;
            release_total_reg <= '0;
            alloc_bits_reg    <= '0;
            k_reg             <= '0;
            dec_ok_reg        <= 1'b0;
        end
        else
        begin
            depth_reg         <= depth_next;
            pages_reg         <= pages_next;
            in_use_reg        <= in_use_next;
            peak_reg          <= peak_next;
            alloc_total_reg   <= alloc_total_next;
            release_total_reg <= release_total_next;
            alloc_bits_reg    <= alloc_bits_next;
            k_reg             <= k_next;
            dec_ok_reg        <= dec_ok_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg    <= in_kind;
            addr_reg    <= in_addr;
            status_reg  <= STATUS_OK;
            granted_reg <= '0;
        end
        if (cmd.layout_a)
        begin
            obj_reg   <= obj_c;
            left_reg  <= left_c;
            inter_reg <= inter_c;
            nblk_reg  <= nblk_c;
            limit_reg <= limit_c;
        end
        if (cmd.layout_b)
        begin
            body_reg   <= 14'(obj_reg) + {6'd0, cfg.pad_bytes, 1'b0} + 14'(cfg.header_bytes);
        end
        if (cmd.layout_c)
        begin
            stride_reg    <= 15'(body_reg) + 15'(inter_reg);
            first_reg     <= 11'(POINTER_BYTES) + 11'(left_reg) + 11'(cfg.header_bytes)
                             + 11'(cfg.pad_bytes);
            // page size is the pointer and left gap plus n strides less one inter gap
            page_size_reg <= 20'(POINTER_BYTES) + 20'(left_reg)
                             + 20'(nblk_reg) * (20'(body_reg) + 20'(inter_reg))
                             - 20'(inter_reg);
        end
        if (cmd.no_pages)
        begin
            status_reg <= STATUS_NO_PAGES;
        end
        if (cmd.decode_start)
        begin
            rem_reg  <= off - 16'(first_reg);
            slot_reg <= '0;
        end
        if (cmd.decode_step && !stat.dec_hit && !stat.dec_miss)
        begin
            rem_reg  <= rem_reg - 16'(stride_reg);
            slot_reg <= slot_reg + 5'd1;
        end
        if (cmd.grant)
        begin
            granted_reg <= {g_page, g_off[PAGE_OFFSET_BITS-1:0]};
        end
        if (cmd.release_blk)
        begin
            status_reg <= rel_status;
        end
        if (cmd.load_result)
        begin
            res_reg.status           <= status_reg;
            res_reg.granted_address  <= granted_reg;
            res_reg.objects_in_use   <= in_use_reg;
            res_reg.free_blocks      <= depth_reg;
            res_reg.pages_in_use     <= pages_reg;
            res_reg.peak_objects     <= peak_reg;
            res_reg.allocation_count <= alloc_total_reg;
            res_reg.release_count    <= release_total_reg;
        end
    end

    // free stack memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            stack_mem[depth_reg[IDX_W-1:0]] <= mem_wdata;
        end
        if (cmd.pop)
        begin
            rd_reg <= stack_mem[depth_m1];
        end
    end

    assign res = res_reg;
endmodule

FILE: rtl/paged_fixed_block_pool_allocator.sv
// top level of the paged fixed-size block pool allocator
`include "paged_fixed_block_pool_allocator_assert.svh"
// Fixed-size block pool over up to sixteen pages of sixteen blocks. Each request item
// is an init, an allocate or a free; each gives exactly one result item carrying a
// status, the granted address and a snapshot of the usage counters. The block works
// on one item at a time: ready is high only when idle, while a finished result may
// still sit in the output register waiting to be taken. An item is accepted in idle,
// works out the page layout from the registers in layout states A, B and C and is
// dispatched. An allocate from a non-empty free list then pops with a stack read,
// grants and loads the result; one that has to create a page first pushes one block
// a cycle (blocks_per_page, up to 16); an init is the same push loop and a result
// load; a failed allocate or an unknown kind goes straight to the result load; a
// free passing the bounds precheck walks the slots one stride subtract a cycle, then
// commits and loads the result, one failing it commits at once. The push loop on the
// single stack write port and the stride walk set how long an item takes. No clearing
// pass follows reset. Config registers sit on an apb port at byte address 4 times the
// register number; the user must write them only while idle (not enforced by the block).
module paged_fixed_block_pool_allocator (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pfa_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    pfa_req_if.sink                     req,
    pfa_res_if.source                   res
);
    import pfa_pkg::*;

    pfa_cfg_t    cfg;
    pfa_cmd_t    cmd;
    pfa_stat_t   stat;
    pfa_result_t res_data;

    // register file
    pfa_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // sequencer: owns the handshakes and issues one command a cycle
    pfa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (res.valid),
        .out_ready (res.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // datapath: layout, free stack, allocated bits and counters
    pfa_dp u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .in_kind (req.kind),
        .in_addr (req.block_address),
        .cmd     (cmd),
        .stat    (stat),
        .res     (res_data)
    );

    assign res.status           = res_data.status;
    assign res.granted_address  = res_data.granted_address;
    assign res.objects_in_use   = res_data.objects_in_use;
    assign res.free_blocks      = res_data.free_blocks;
    assign res.pages_in_use     = res_data.pages_in_use;
    assign res.peak_objects     = res_data.peak_objects;
    assign res.allocation_count = res_data.allocation_count;
    assign res.release_count    = res_data.release_count;

    // at most one datapath operation a cycle
    `PFA_ASSERT_IMP(a_single_cmd, 1'b1, $onehot0({cmd.push, cmd.pop, cmd.grant, cmd.decode_step, cmd.release_blk, cmd.load_result}))
    // never pop an empty free list
    `PFA_ASSERT_IMP(a_pop_nonempty, cmd.pop, !stat.stack_empty)
    // one item in flight: no second accept straight after the first
    `PFA_ASSERT_NXT(a_one_in_flight, req.valid && req.ready, !req.ready)
    // a loaded result is presented
    `PFA_ASSERT_NXT(a_result_shown, cmd.load_result, res.valid)
endmodule

FILE: dv/paged_fixed_block_pool_allocator_tb.sv
// testbench for the paged fixed-size block pool allocator: random and directed items against a predictor
`timescale 1ns / 100ps
module paged_fixed_block_pool_allocator_tb;
    import pfa_pkg::*;

    typedef struct packed {
        logic [1:0]  kind;
        logic [19:0] addr;
    } req_item_t;

    typedef struct {
        int unsigned obj, pad, hdr, first, stride, nblk, page_size;
    } geometry_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    pfa_req_if req ();
    pfa_res_if res ();

    paged_fixed_block_pool_allocator uut (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .req(req.sink), .res(res.source)
    );

    always #6 clk = ~clk;

    // predictor copy of the registers and the pool
    int unsigned cfg_obj = 8, cfg_pad = 0, cfg_hdr = 0, cfg_align = 0;
    int unsigned cfg_bpp = 4, cfg_limit = 16, cfg_debug = 0;
    logic [7:0] pool_stack [POOL_CAPACITY];
    bit pool_taken [POOL_CAPACITY];
    int unsigned pool_depth = 0, pool_pages = 0, pool_in_use = 0, pool_peak = 0;
    logic [31:0] pool_allocs = 0, pool_frees = 0;

    req_item_t   pending_items [$];
    pfa_result_t expected_results [$];
    int unsigned mismatches = 0, results_seen = 0, cycle = 0;
    bit no_idle = 1'b0;
    bit hold_send = 1'b0;
    bit item_taken = 1'b0;
    int send_gap = 0, take_gap = 0;

    function automatic geometry_t pool_geometry();
        geometry_t g;
        int unsigned n1, n2, left, inter;
        g.obj = (cfg_obj < POINTER_BYTES) ? POINTER_BYTES : cfg_obj;
        g.pad = cfg_pad;
        g.hdr = cfg_hdr;
        left = 0;
        inter = 0;
        if (cfg_align != 0)
        begin
            n1 = POINTER_BYTES + g.pad + g.hdr;
            n2 = g.hdr + 2 * g.pad;
            left = (n1 <= cfg_align) ? cfg_align - n1 : ((2 * cfg_align > n1) ? 2 * cfg_align - n1 : 0);
            inter = (n2 < cfg_align) ? cfg_align - n2 : ((2 * cfg_align > n2) ? 2 * cfg_align - n2 : 0);
        end
        g.nblk = (cfg_bpp < 1) ? 1 : ((cfg_bpp > MAX_BLOCKS_PER_PAGE) ? MAX_BLOCKS_PER_PAGE : cfg_bpp);
        g.stride = g.obj + 2 * g.pad + g.hdr + inter;
        g.first = POINTER_BYTES + left + g.hdr + g.pad;
        g.page_size = POINTER_BYTES + left + g.nblk * (g.obj + 2 * g.pad + g.hdr)
                    + (g.nblk - 1) * inter;
        return g;
    endfunction

    function automatic void push_free(int unsigned idx);
        if (pool_depth < POOL_CAPACITY)
        begin
            pool_stack[pool_depth] = idx[7:0];
            pool_depth++;
        end
    endfunction

    function automatic void grow_pool(geometry_t g);
        if (pool_pages >= MAX_PAGES)
            return;
        for (int unsigned k = 0; k < g.nblk; k++)
            push_free(pool_pages * MAX_BLOCKS_PER_PAGE + k);
        pool_pages++;
    endfunction

    function automatic pfa_result_t pool_step(req_item_t it);
        geometry_t g;
        pfa_result_t r;
        int unsigned lim, idx, pg, off, slot;
        bit hit, accept;
        g = pool_geometry();
        r = '0;
        lim = (cfg_limit > MAX_PAGES) ? MAX_PAGES : cfg_limit;
        if (it.kind == KIND_INIT)
        begin
            foreach (pool_taken[i]) pool_taken[i] = 1'b0;
            pool_depth = 0; pool_pages = 0; pool_in_use = 0; pool_peak = 0;
            pool_allocs = 0; pool_frees = 0;
            grow_pool(g);
        end
        else if (it.kind == KIND_ALLOC)
        begin
            if (pool_depth == 0 && pool_pages < lim)
                grow_pool(g);
            if (pool_depth == 0)
                r.status = STATUS_NO_PAGES;
            else
            begin
                pool_depth--;
                idx = 32'(pool_stack[pool_depth]);
                off = (g.first + (idx % MAX_BLOCKS_PER_PAGE) * g.stride) & 16'hFFFF;
                r.granted_address = ADDR_W'(((idx / MAX_BLOCKS_PER_PAGE) << PAGE_OFFSET_BITS) | off);
                pool_taken[idx] = 1'b1;
                pool_in_use++;
                if (pool_in_use > pool_peak) pool_peak = pool_in_use;
                pool_allocs++;
            end
        end
        else if (it.kind == KIND_FREE)
        begin
            pg = 32'(it.addr) >> PAGE_OFFSET_BITS;
            off = 32'(it.addr) & 16'hFFFF;
            hit = 1'b0;
            idx = 0;
            if (pg < pool_pages && off != 0 && off < g.page_size && off >= g.first
                && (off - g.first) % g.stride == 0)
            begin
                slot = (off - g.first) / g.stride;
                if (slot < g.nblk)
                begin
                    hit = 1'b1;
                    idx = pg * MAX_BLOCKS_PER_PAGE + slot;
                end
            end
            accept = hit;
            if (cfg_debug != 0)
            begin
                if (!hit) r.status = STATUS_BAD_BOUNDARY;
                else if (!pool_taken[idx])
                begin
                    r.status = STATUS_MULTIPLE_FREE;
                    accept = 1'b0;
                end
            end
            if (accept)
            begin
                pool_taken[idx] = 1'b0;
                push_free(idx);
                if (pool_in_use > 0) pool_in_use--;
                pool_frees++;
            end
        end
        r.objects_in_use = CNT_W'(pool_in_use);
        r.free_blocks = CNT_W'(pool_depth);
        r.pages_in_use = PAGES_W'(pool_pages);
        r.peak_objects = CNT_W'(pool_peak);
        r.allocation_count = pool_allocs;
        r.release_count = pool_frees;
        return r;
    endfunction

    // driver: presents queued items, lowers valid once the item has been taken
    initial
    begin
        req.valid = 1'b0;
        req.kind = '0;
        req.block_address = '0;
        res.ready = 1'b0;
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (item_taken)
            begin
                item_taken = 1'b0;
                req.valid <= 1'b0;
            end
            if (send_gap > 0)
                send_gap--;
            else if (!hold_send && pending_items.size() > 0 && !(req.valid && !req.ready))
            begin
                if (!no_idle && $urandom_range(0, 7) == 0)
                    send_gap = $urandom_range(1, 12);
                else
                begin
                    req.valid <= 1'b1;
                    req.kind <= pending_items[0].kind;
                    req.block_address <= pending_items[0].addr;
                end
            end
            if (take_gap > 0)
            begin
                take_gap--;
                res.ready <= 1'b0;
            end
            else if (!no_idle && $urandom_range(0, 7) == 0)
            begin
                take_gap = $urandom_range(1, 12);
                res.ready <= 1'b0;
            end
            else
                res.ready <= 1'b1;
        end
    end

    // monitor: predicts each request item at its accepting edge and compares each
    // result item with the oldest prediction
    always @(posedge clk)
    begin
        cycle++;
        if (rst_n && res.valid && res.ready)
        begin
            pfa_result_t got, want;
            got = {res.status, res.granted_address, res.objects_in_use, res.free_blocks,
                   res.pages_in_use, res.peak_objects, res.allocation_count,
                   res.release_count};
            results_seen++;
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result item %h", got);
            end
            else
            begin
                want = expected_results.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected st=%0d ga=%h use=%0d fr=%0d pg=%0d pk=%0d al=%0d rl=%0d, got st=%0d ga=%h use=%0d fr=%0d pg=%0d pk=%0d al=%0d rl=%0d",
                            want.status, want.granted_address, want.objects_in_use,
                            want.free_blocks, want.pages_in_use, want.peak_objects,
                            want.allocation_count, want.release_count,
                            got.status, got.granted_address, got.objects_in_use,
                            got.free_blocks, got.pages_in_use, got.peak_objects,
                            got.allocation_count, got.release_count);
                end
            end
        end
        if (rst_n && req.valid && req.ready)
        begin
            expected_results.push_back(pool_step({req.kind, req.block_address}));
            void'(pending_items.pop_front());
            item_taken = 1'b1;
        end
        if (cycle > 2000000)
        begin
            $display("timeout");
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_items.size() > 0 || req.valid || expected_results.size() > 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic write_reg(pfa_reg_t r, int unsigned v);
        @(negedge clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= PADDR_W'(4 * int'(r)); pwdata <= v;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (r)
            REG_OBJECT_BYTES:    cfg_obj = v & 13'h1FFF;
            REG_PAD_BYTES:       cfg_pad = v & 7'h7F;
            REG_HEADER_BYTES:    cfg_hdr = v & 6'h3F;
            REG_ALIGNMENT_BYTES: cfg_align = v & 9'h1FF;
            REG_BLOCKS_PER_PAGE: cfg_bpp = v & 5'h1F;
            REG_PAGE_LIMIT:      cfg_limit = v & 5'h1F;
            default:             cfg_debug = v & 1;
        endcase
    endtask

    task automatic queue_item(pfa_kind_t k, logic [19:0] a);
        req_item_t it;
        it.kind = k;
        it.addr = a;
        pending_items.push_back(it);
    endtask

    // a free aimed mostly at real slots, sometimes off by one to three bytes or anywhere
    function automatic logic [19:0] pick_free_address();
        geometry_t g;
        int unsigned pg, slot, off;
        g = pool_geometry();
        pg = $urandom_range(0, (pool_pages > 0) ? pool_pages : 1);
        slot = $urandom_range(0, g.nblk);
        off = g.first + slot * g.stride;
        case ($urandom_range(0, 9))
            0: return 20'($urandom());
            1: off = off + $urandom_range(1, 3);
            default: ;
        endcase
        return {pg[3:0], off[15:0]};
    endfunction

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++)
        begin
            int unsigned sel;
            sel = $urandom_range(0, 99);
            if (sel < 2) queue_item(KIND_INIT, 20'($urandom()));
            else if (sel < 50) queue_item(KIND_ALLOC, 20'($urandom()));
            else if (sel < 97)
            begin
                // the address picker reads predictor state, so keep it current
                while (pending_items.size() > 0) @(posedge clk);
                queue_item(KIND_FREE, pick_free_address());
            end
            else
            begin
                req_item_t it;
                it.kind = 2'd3;
                it.addr = 20'($urandom());
                pending_items.push_back(it);
            end
        end
        wait_drained();
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: allocate before init, init, exhaust, bad frees, double free, odd kind
        queue_item(KIND_ALLOC, 20'h0);
        queue_item(KIND_INIT, 20'hFFFFF);
        for (int i = 0; i < 5; i++) queue_item(KIND_ALLOC, 20'h0);
        queue_item(KIND_FREE, 20'h00008);
        queue_item(KIND_FREE, 20'h00008);
        queue_item(KIND_FREE, 20'h00000);
        queue_item(KIND_FREE, 20'hFFFFF);
        pending_items.push_back({2'd3, 20'hFFFFF});
        wait_drained();
        write_reg(REG_DEBUG_CHECKS, 1);
        write_reg(REG_PAGE_LIMIT, 1);
        write_reg(REG_BLOCKS_PER_PAGE, 1);
        queue_item(KIND_INIT, 20'h0);
        queue_item(KIND_ALLOC, 20'h0);
        queue_item(KIND_ALLOC, 20'h0);
        queue_item(KIND_FREE, 20'h00008);
        queue_item(KIND_FREE, 20'h00008);
        queue_item(KIND_FREE, 20'h00009);
        queue_item(KIND_FREE, 20'h10008);
        wait_drained();
        write_reg(REG_PAGE_LIMIT, 0);
        queue_item(KIND_INIT, 20'h0);
        queue_item(KIND_ALLOC, 20'h0);
        queue_item(KIND_ALLOC, 20'h0);
        wait_drained();

        // random phases across settings, extremes included
        for (int ph = 0; ph < 10; ph++)
        begin
            case (ph)
                0: begin write_reg(REG_OBJECT_BYTES, 4096); write_reg(REG_PAD_BYTES, 64);
                         write_reg(REG_HEADER_BYTES, 32); write_reg(REG_ALIGNMENT_BYTES, 256);
                         write_reg(REG_BLOCKS_PER_PAGE, 16); write_reg(REG_PAGE_LIMIT, 16); end
                1: begin write_reg(REG_OBJECT_BYTES, 0); write_reg(REG_PAD_BYTES, 0);
                         write_reg(REG_HEADER_BYTES, 0); write_reg(REG_ALIGNMENT_BYTES, 0);
                         write_reg(REG_BLOCKS_PER_PAGE, 0); write_reg(REG_PAGE_LIMIT, 31); end
                2: begin write_reg(REG_OBJECT_BYTES, 8191); write_reg(REG_PAD_BYTES, 127);
                         write_reg(REG_HEADER_BYTES, 63); write_reg(REG_ALIGNMENT_BYTES, 511);
                         write_reg(REG_BLOCKS_PER_PAGE, 31); write_reg(REG_DEBUG_CHECKS, 0); end
                default: begin
                    write_reg(REG_OBJECT_BYTES, $urandom_range(0, 300));
                    write_reg(REG_PAD_BYTES, $urandom_range(0, 64));
                    write_reg(REG_HEADER_BYTES, $urandom_range(0, 32));
                    write_reg(REG_ALIGNMENT_BYTES, $urandom_range(0, 1) ? 0 : (1 << $urandom_range(0, 8)));
                    write_reg(REG_BLOCKS_PER_PAGE, $urandom_range(1, 16));
                    write_reg(REG_PAGE_LIMIT, $urandom_range(1, 16));
                    write_reg(REG_DEBUG_CHECKS, $urandom_range(0, 1));
                end
            endcase
            if (ph == 9) no_idle = 1'b1;
            queue_item(KIND_INIT, 20'h0);
            random_phase(140);
            if (ph == 4)
            begin
                // sender holds off until every result is in
                hold_send = 1'b1;
                queue_item(KIND_ALLOC, 20'h0);
                while (expected_results.size() > 0) @(posedge clk);
                hold_send = 1'b0;
                wait_drained();
            end
        end

        wait_drained();
        $display("covered init, allocate and free over ten register settings, debug on and off");
        $display("%0d result items checked, %0d mismatches", results_seen, mismatches);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

FILE: paged_fixed_block_pool_allocator.f
+incdir+rtl
rtl/pfa_pkg.sv
rtl/pfa_if.sv
rtl/pfa_regs.sv
rtl/pfa_ctrl.sv
rtl/pfa_dp.sv
rtl/paged_fixed_block_pool_allocator.sv
dv/paged_fixed_block_pool_allocator_tb.sv
